// ===== rtl/isd_pkg.sv =====
// Shared types and constants for the interval set table.
// Holds the request and response items, the request codes, the controller
// states, the datapath operation codes and the status group. No dependencies.
package isd_pkg;

  // Default sizes of the boundary store.
  localparam int MAX_BOUNDS_DEF = 64;
  localparam int POS_WIDTH_DEF  = 32;

  // Largest value the 31-bit result position can carry.
  localparam int OUT_POS_MAX = 2147483647;

  // Request codes.
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_LOCATE = 3'd3;
  localparam logic [2:0] REQ_SPAN   = 3'd4;
  localparam logic [2:0] REQ_EXPAND = 3'd5;

  // One input item.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [30:0] position;
    logic [30:0] length;
    logic        flag_bit;
  } isd_req_t;

  // One result item.
  typedef struct packed {
    logic               status;
    logic signed [7:0]  found_index;
    logic [30:0]        result_pos;
    logic signed [31:0] span_len;
  } isd_rsp_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_IDX,
    OP_INC,
    OP_LOC_STEP,
    OP_LOC_DONE,
    OP_LOC_OUT,
    OP_SPAN_MID,
    OP_SPAN_END,
    OP_BIAS_ON,
    OP_ADD_MARK,
    OP_SET_FAIL,
    OP_SH_INIT,
    OP_SH_WR,
    OP_IDX_POS,
    OP_WR_POS_STOP,
    OP_WR_POS_OFF,
    OP_WR_POS1_STOP,
    OP_WR_POS2M1_STOP,
    OP_RD_POS1,
    OP_OG_INIT,
    OP_RD_IDXM1,
    OP_OG_WR,
    OP_CNT_ADD2,
    OP_SET_GAP2,
    OP_SET_GAPD,
    OP_CG_INIT,
    OP_CG_WR,
    OP_CG_END,
    OP_DEL_MARK,
    OP_MARK2,
    OP_POS2_ADD2,
    OP_DEL_ADJ,
    OP_EXP_A,
    OP_EXP_B,
    OP_EXP_OUT,
    OP_EMIT
  } isd_op_t;

  // Controller states.
  typedef enum logic [5:0] {
    S_IDLE,
    S_DISPATCH,
    S_LC_RD,
    S_LC_EV,
    S_LC_DONE,
    S_LC_NEXT,
    S_AS_RD,
    S_AS_EV,
    S_AS_MARK,
    S_AS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_AP,
    S_AP_CK,
    S_AP_CE,
    S_AP_W0,
    S_AP_W1,
    S_OG_INIT,
    S_OG_RD,
    S_OG_WR,
    S_CG_INIT,
    S_CG_RD,
    S_CG_WR,
    S_DS_RD,
    S_DS_EV,
    S_D2_RD,
    S_D2_EV,
    S_D2_MARK,
    S_DL_A,
    S_DL_WPOS,
    S_DL_B,
    S_DL_C,
    S_DL_D,
    S_DL_SUB,
    S_EX_RD,
    S_EX_EV,
    S_EX_RD2,
    S_EX_EV2,
    S_EMIT
  } isd_state_t;

  // Status reported by the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       zero_len;
    logic       idx_lt_cnt;
    logic       loc_go;
    logic       add_go;
    logic       full;
    logic       del_lt;
    logic       del_le;
    logic       og_go;
    logic       pos_odd;
    logic       pos2_odd;
    logic       pos_eq_pos2;
    logic       pos_lt_pos2;
    logic       pos1_lt_cnt;
    logic       close_match;
    logic       exp_ok;
    logic       exp_le;
    logic       eq_off;
    logic       eq_stop;
    logic       ins_match;
    logic       second;
    logic       emit_ok;
  } isd_stat_t;

endpackage

// ===== rtl/isd_ctrl.sv =====
// Controller state machine of the interval set table.
// Sequences the scan, shift and gap passes by issuing datapath operations.
// Depends on isd_pkg.
module isd_ctrl import isd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  isd_stat_t stat,
  output isd_op_t   op
);

  isd_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and operation select.
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req_type)
          REQ_ADD:    state_next = stat.zero_len ? S_EMIT : S_AS_RD;
          REQ_INSERT: state_next = stat.zero_len ? S_EMIT : S_LC_RD;
          REQ_DELETE: state_next = stat.zero_len ? S_EMIT : S_DS_RD;
          REQ_LOCATE, REQ_SPAN: state_next = S_LC_RD;
          REQ_EXPAND: state_next = S_EX_RD;
          default:    state_next = S_EMIT;
        endcase
      end
      // Locate scan: read a boundary, then evaluate it.
      S_LC_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_LC_EV;
        end else begin
          state_next = S_LC_DONE;
        end
      end
      S_LC_EV: begin
        if (stat.loc_go) begin
          op         = OP_LOC_STEP;
          state_next = S_LC_RD;
        end else begin
          state_next = S_LC_DONE;
        end
      end
      S_LC_DONE: begin
        op         = OP_LOC_DONE;
        state_next = S_LC_NEXT;
      end
      S_LC_NEXT: begin
        case (stat.req_type)
          REQ_LOCATE: begin
            op         = OP_LOC_OUT;
            state_next = S_EMIT;
          end
          REQ_SPAN: begin
            if (stat.second) begin
              op         = OP_SPAN_END;
              state_next = S_EMIT;
            end else begin
              op         = OP_SPAN_MID;
              state_next = S_LC_RD;
            end
          end
          default: begin
            if (stat.ins_match) begin
              op         = OP_BIAS_ON;
              state_next = S_AS_RD;
            end else begin
              op         = OP_SH_INIT;
              state_next = S_SH_RD;
            end
          end
        endcase
      end
      // Add scan: find the first boundary not below the start.
      S_AS_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_AS_EV;
        end else begin
          state_next = S_AS_MARK;
        end
      end
      S_AS_EV: begin
        if (stat.add_go) begin
          op         = OP_INC;
          state_next = S_AS_RD;
        end else begin
          state_next = S_AS_MARK;
        end
      end
      S_AS_MARK: begin
        op         = OP_ADD_MARK;
        state_next = S_AS_CHK;
      end
      S_AS_CHK: begin
        if (!stat.eq_off && !stat.eq_stop && stat.full) begin
          op         = OP_SET_FAIL;
          state_next = S_EMIT;
        end else if (stat.req_type == REQ_INSERT) begin
          op         = OP_SH_INIT;
          state_next = S_SH_RD;
        end else begin
          state_next = S_AP;
        end
      end
      // Shift pass: add or subtract the length from the tail boundaries.
      S_SH_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_SH_WR;
        end else if (stat.req_type == REQ_INSERT && stat.ins_match) begin
          state_next = S_AP;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SH_WR: begin
        op         = OP_SH_WR;
        state_next = S_SH_RD;
      end
      // Apply the range found by the add scan.
      S_AP: begin
        if (stat.eq_off) begin
          op         = OP_WR_POS_STOP;
          state_next = S_AP_CK;
        end else if (stat.eq_stop) begin
          op         = OP_WR_POS_OFF;
          state_next = S_EMIT;
        end else begin
          op         = OP_OG_INIT;
          state_next = S_OG_RD;
        end
      end
      S_AP_CK: begin
        if (stat.pos1_lt_cnt) begin
          op         = OP_RD_POS1;
          state_next = S_AP_CE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_AP_CE: begin
        if (stat.close_match) begin
          op         = OP_SET_GAP2;
          state_next = S_CG_INIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_AP_W0: begin
        op         = OP_WR_POS_OFF;
        state_next = S_AP_W1;
      end
      S_AP_W1: begin
        op         = OP_WR_POS1_STOP;
        state_next = S_EMIT;
      end
      // Open a gap of two entries, moving from the top down.
      S_OG_INIT: begin
        op         = OP_OG_INIT;
        state_next = S_OG_RD;
      end
      S_OG_RD: begin
        if (stat.og_go) begin
          op         = OP_RD_IDXM1;
          state_next = S_OG_WR;
        end else begin
          op         = OP_CNT_ADD2;
          state_next = (stat.req_type == REQ_DELETE) ? S_DL_WPOS : S_AP_W0;
        end
      end
      S_OG_WR: begin
        op         = OP_OG_WR;
        state_next = S_OG_RD;
      end
      // Close a gap, moving from the bottom up.
      S_CG_INIT: begin
        op         = OP_CG_INIT;
        state_next = S_CG_RD;
      end
      S_CG_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_CG_WR;
        end else begin
          op         = OP_CG_END;
          state_next = (stat.req_type == REQ_DELETE) ? S_DL_SUB : S_EMIT;
        end
      end
      S_CG_WR: begin
        op         = OP_CG_WR;
        state_next = S_CG_RD;
      end
      // Delete: find the first boundary at or after the start.
      S_DS_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_DS_EV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DS_EV: begin
        if (stat.del_lt) begin
          op         = OP_INC;
          state_next = S_DS_RD;
        end else begin
          op         = OP_DEL_MARK;
          state_next = S_D2_RD;
        end
      end
      // Then the first boundary past the end of the cut.
      S_D2_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = OP_RD_IDX;
          state_next = S_D2_EV;
        end else begin
          state_next = S_D2_MARK;
        end
      end
      S_D2_EV: begin
        if (stat.del_le) begin
          op         = OP_INC;
          state_next = S_D2_RD;
        end else begin
          state_next = S_D2_MARK;
        end
      end
      S_D2_MARK: begin
        op         = OP_MARK2;
        state_next = S_DL_A;
      end
      S_DL_A: begin
        if (stat.pos_odd) begin
          if (stat.pos_eq_pos2) begin
            if (stat.full) begin
              op         = OP_SET_FAIL;
              state_next = S_EMIT;
            end else begin
              op         = OP_POS2_ADD2;
              state_next = S_OG_INIT;
            end
          end else begin
            state_next = S_DL_WPOS;
          end
        end else begin
          state_next = S_DL_B;
        end
      end
      S_DL_WPOS: begin
        op         = OP_WR_POS_OFF;
        state_next = S_DL_B;
      end
      S_DL_B: begin
        if (stat.pos2_odd) begin
          op = OP_WR_POS2M1_STOP;
        end
        state_next = S_DL_C;
      end
      S_DL_C: begin
        op         = OP_DEL_ADJ;
        state_next = S_DL_D;
      end
      S_DL_D: begin
        if (stat.pos_lt_pos2) begin
          op         = OP_SET_GAPD;
          state_next = S_CG_INIT;
        end else begin
          state_next = S_DL_SUB;
        end
      end
      S_DL_SUB: begin
        op         = OP_IDX_POS;
        state_next = S_SH_RD;
      end
      // Expand: walk range pairs while they start at or before the position.
      S_EX_RD: begin
        if (stat.exp_ok) begin
          op         = OP_RD_IDX;
          state_next = S_EX_EV;
        end else begin
          op         = OP_EXP_OUT;
          state_next = S_EMIT;
        end
      end
      S_EX_EV: begin
        if (stat.exp_le) begin
          op         = OP_EXP_A;
          state_next = S_EX_RD2;
        end else begin
          op         = OP_EXP_OUT;
          state_next = S_EMIT;
        end
      end
      S_EX_RD2: begin
        op         = OP_RD_IDX;
        state_next = S_EX_EV2;
      end
      S_EX_EV2: begin
        op         = OP_EXP_B;
        state_next = S_EX_RD;
      end
      S_EMIT: begin
        if (stat.emit_ok) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/isd_dpath.sv =====
// Datapath of the interval set table: boundary memory, pointers, running sums
// and the result register. Executes one controller operation per cycle.
// Depends on isd_pkg.
module isd_dpath import isd_pkg::*; #(
  parameter int MAX_BOUNDS = MAX_BOUNDS_DEF,
  parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  isd_op_t   op,
  input  isd_req_t  req,
  output isd_stat_t stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output isd_rsp_t  rsp
);

  localparam int IDX_W  = $clog2(MAX_BOUNDS);
  localparam int CNT_W  = $clog2(MAX_BOUNDS + 1);
  localparam int FILL_W = 34 + CNT_W;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic signed [FILL_W-1:0] POS_MAX_W =
    signed'({{(FILL_W - POS_WIDTH){1'b0}}, POS_MAX});
  localparam logic signed [FILL_W-1:0] OUT_MAX_W = FILL_W'(OUT_POS_MAX);
  localparam logic [CNT_W-1:0] FULL_LIM = CNT_W'(MAX_BOUNDS - 2);
  localparam logic signed [FILL_W:0] S32_MAX = (FILL_W + 1)'(32'sh7FFFFFFF);
  localparam logic signed [FILL_W:0] S32_MIN = (FILL_W + 1)'(-33'sh80000000);

  function automatic logic signed [FILL_W-1:0] wext(input logic [POS_WIDTH-1:0] v);
    return signed'({{(FILL_W - POS_WIDTH){1'b0}}, v});
  endfunction

  function automatic logic [POS_WIDTH-1:0] clamp_b(input logic signed [FILL_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > POS_MAX_W) begin
      return POS_MAX;
    end
    return v[POS_WIDTH-1:0];
  endfunction

  function automatic logic [30:0] sat_pos(input logic signed [FILL_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > OUT_MAX_W) begin
      return '1;
    end
    return v[30:0];
  endfunction

  // Boundary store and registered read data.
  logic [POS_WIDTH-1:0] mem [MAX_BOUNDS];
  logic [POS_WIDTH-1:0] rdata;

  isd_req_t                  rq;
  logic [CNT_W-1:0]          cnt, idx, pos, pos2, gapn;
  logic signed [CNT_W:0]     loc;
  logic [POS_WIDTH-1:0]      last, prev;
  logic signed [FILL_W-1:0]  fill, loc_off, rs, acc, tgt;
  logic                      bias, second, eq_off, eq_stop;
  isd_rsp_t                  res;

  // Values derived from the request and the scan registers.
  logic signed [FILL_W-1:0] off_w, len_w, stop_w, rd_w, view_w, fi, local_new, adj;
  logic signed [FILL_W-1:0] loc_w;
  logic signed [FILL_W:0]   span_w;
  logic signed [CNT_W:0]    idx_s, loc_new;
  logic [CNT_W:0]           idx_p1, pos_p1;
  logic [CNT_W-1:0]         a_idx_m1, a_idx_p1, a_pos_p1, a_pos2_m1, a_cg;
  logic                     re, we;
  logic [IDX_W-1:0]         raddr, waddr;
  logic [POS_WIDTH-1:0]     wdata;

  always_comb begin
    off_w   = signed'({{(FILL_W - 31){1'b0}}, rq.position});
    len_w   = signed'({{(FILL_W - 31){1'b0}}, rq.length});
    stop_w  = off_w + len_w;
    rd_w    = wext(rdata);
    idx_s   = signed'({1'b0, idx});
    loc_new = idx_s - (CNT_W + 1)'(1);
    view_w  = (bias && (idx_s > loc)) ? wext(clamp_b(rd_w + len_w)) : rd_w;
    fi      = loc_new[0] ? (wext(last) - fill) : fill;
    local_new = fi + tgt - wext(last);
    adj     = (loc[0] ^ rq.flag_bit) ? (tgt - loc_off) : loc_off;
    span_w  = {adj[FILL_W-1], adj} - {rs[FILL_W-1], rs};
    loc_w   = FILL_W'(loc);
    idx_p1  = {1'b0, idx} + (CNT_W + 1)'(1);
    pos_p1  = {1'b0, pos} + (CNT_W + 1)'(1);
    a_idx_m1  = idx - CNT_W'(1);
    a_idx_p1  = idx + CNT_W'(1);
    a_pos_p1  = pos + CNT_W'(1);
    a_pos2_m1 = pos2 - CNT_W'(1);
    a_cg      = idx - gapn;
  end

  // Status toward the controller.
  always_comb begin
    stat.req_type    = rq.req_type;
    stat.zero_len    = (rq.length == '0);
    stat.idx_lt_cnt  = (idx < cnt);
    stat.loc_go      = (tgt >= rd_w);
    stat.add_go      = (off_w > view_w);
    stat.full        = (cnt > FULL_LIM);
    stat.del_lt      = (rd_w < off_w);
    stat.del_le      = (rd_w <= stop_w);
    stat.og_go       = (idx > pos);
    stat.pos_odd     = pos[0];
    stat.pos2_odd    = pos2[0];
    stat.pos_eq_pos2 = (pos == pos2);
    stat.pos_lt_pos2 = (pos < pos2);
    stat.pos1_lt_cnt = (pos_p1 < {1'b0, cnt});
    stat.close_match = (rdata == clamp_b(stop_w));
    stat.exp_ok      = (idx_p1 < {1'b0, cnt});
    stat.exp_le      = (rd_w <= acc);
    stat.eq_off      = eq_off;
    stat.eq_stop     = eq_stop;
    stat.ins_match   = (rq.flag_bit == loc[0]);
    stat.second      = second;
    stat.emit_ok     = !rsp_valid || rsp_ready;
  end

  // Memory port select.
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx[IDX_W-1:0];
    waddr = idx[IDX_W-1:0];
    wdata = clamp_b(stop_w);
    case (op)
      OP_RD_IDX:   re = 1'b1;
      OP_RD_IDXM1: begin
        re    = 1'b1;
        raddr = a_idx_m1[IDX_W-1:0];
      end
      OP_RD_POS1: begin
        re    = 1'b1;
        raddr = a_pos_p1[IDX_W-1:0];
      end
      OP_SH_WR: begin
        we    = 1'b1;
        wdata = (rq.req_type == REQ_DELETE) ? clamp_b(rd_w - len_w) : clamp_b(rd_w + len_w);
      end
      OP_OG_WR: begin
        we    = 1'b1;
        waddr = a_idx_p1[IDX_W-1:0];
        wdata = rdata;
      end
      OP_CG_WR: begin
        we    = 1'b1;
        waddr = a_cg[IDX_W-1:0];
        wdata = rdata;
      end
      OP_WR_POS_STOP: begin
        we    = 1'b1;
        waddr = pos[IDX_W-1:0];
      end
      OP_WR_POS_OFF: begin
        we    = 1'b1;
        waddr = pos[IDX_W-1:0];
        wdata = clamp_b(off_w);
      end
      OP_WR_POS1_STOP: begin
        we    = 1'b1;
        waddr = a_pos_p1[IDX_W-1:0];
      end
      OP_WR_POS2M1_STOP: begin
        we    = 1'b1;
        waddr = a_pos2_m1[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // Boundary memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Boundary count and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (op)
        OP_CNT_ADD2: cnt <= cnt + CNT_W'(2);
        OP_CG_END:   cnt <= cnt - gapn;
        default: ;
      endcase
      if (op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        rq      <= req;
        idx     <= '0;
        last    <= '0;
        fill    <= '0;
        acc     <= signed'({{(FILL_W - 31){1'b0}}, req.position});
        tgt     <= signed'({{(FILL_W - 31){1'b0}}, req.position});
        bias    <= 1'b0;
        second  <= 1'b0;
        eq_off  <= 1'b0;
        eq_stop <= 1'b0;
        res     <= '0;
      end
      OP_INC: idx <= a_idx_p1;
      OP_LOC_STEP: begin
        last <= rdata;
        prev <= rdata;
        if (idx[0]) begin
          fill <= fill + rd_w - wext(prev);
        end
        idx <= a_idx_p1;
      end
      OP_LOC_DONE: begin
        loc     <= loc_new;
        loc_off <= local_new;
      end
      OP_LOC_OUT: begin
        res.found_index <= (loc_w > FILL_W'(127)) ? 8'sd127 : loc_w[7:0];
        res.result_pos  <= sat_pos(loc_off);
      end
      OP_SPAN_MID: begin
        rs     <= adj;
        second <= 1'b1;
        tgt    <= stop_w;
        idx    <= '0;
        last   <= '0;
        fill   <= '0;
      end
      OP_SPAN_END: begin
        res.result_pos <= sat_pos(rs);
        if (span_w > S32_MAX) begin
          res.span_len <= 32'sh7FFFFFFF;
        end else if (span_w < S32_MIN) begin
          res.span_len <= 32'sh80000000;
        end else begin
          res.span_len <= span_w[31:0];
        end
      end
      OP_BIAS_ON: begin
        bias <= 1'b1;
        idx  <= '0;
      end
      OP_ADD_MARK: begin
        pos     <= idx;
        eq_off  <= (idx < cnt) && (view_w == off_w);
        eq_stop <= (idx < cnt) && (view_w == stop_w);
      end
      OP_SET_FAIL:  res.status <= 1'b1;
      OP_SH_INIT:   idx <= CNT_W'(loc + (CNT_W + 1)'(1));
      OP_SH_WR:     idx <= a_idx_p1;
      OP_IDX_POS:   idx <= pos;
      OP_OG_INIT:   idx <= cnt;
      OP_OG_WR:     idx <= a_idx_m1;
      OP_SET_GAP2:  gapn <= CNT_W'(2);
      OP_SET_GAPD:  gapn <= pos2 - pos;
      OP_CG_INIT:   idx <= pos + gapn;
      OP_CG_WR:     idx <= a_idx_p1;
      OP_DEL_MARK:  pos <= idx;
      OP_MARK2:     pos2 <= idx;
      OP_POS2_ADD2: pos2 <= pos2 + CNT_W'(2);
      OP_DEL_ADJ: begin
        if (!(pos[0] & pos2[0])) begin
          pos  <= pos + CNT_W'(pos[0]);
          pos2 <= pos2 - CNT_W'(pos2[0]);
        end
      end
      OP_EXP_A: begin
        prev <= rdata;
        idx  <= a_idx_p1;
      end
      OP_EXP_B: begin
        acc <= acc + rd_w - wext(prev);
        idx <= a_idx_p1;
      end
      OP_EXP_OUT: res.result_pos <= sat_pos(acc);
      OP_EMIT:    rsp <= res;
      default: ;
    endcase
  end

endmodule

// ===== rtl/interval_set_table.sv =====
// Interval set table: a sorted list of up to MAX_BOUNDS boundaries in a
// memory with a read port and a write port, where each pair of entries
// bounds one covered range. Items are handled one at a time. Every pass
// over the list handles one boundary at a time: it reads it, then
// evaluates it or writes it back. An edit scans the list and then shifts
// entries. A new item is taken while the previous result still waits at
// the output. Reset empties the store at once.
// Depends on isd_pkg, isd_ctrl and isd_dpath.
module interval_set_table import isd_pkg::*; #(
  parameter int MAX_BOUNDS = MAX_BOUNDS_DEF,
  parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  isd_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output isd_rsp_t rsp
);

  isd_op_t   op;
  isd_stat_t stat;

  // Sequencer.
  isd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .op        (op)
  );

  // Memory and arithmetic.
  isd_dpath #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .POS_WIDTH  (POS_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .req       (req),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== dv/interval_set_table_tb.sv =====
// Self-checking testbench for the interval set table.
// Drives requests through the valid/ready port, predicts every response with an
// internal boundary-list model, and compares field by field. Depends on isd_pkg.
module interval_set_table_tb import isd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  isd_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  isd_rsp_t rsp;

  // Predicted boundary list and the responses still owed by the block.
  logic [31:0] tbl [TBL_DEPTH];
  int          tbl_n;
  isd_rsp_t    rsp_q [$];
  int          errors;
  bit          quiet;
  int          stall_left;
  int          idle_cycles;

  interval_set_table i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Saturate a boundary value to 32 unsigned bits.
  function automatic logic [31:0] clamp_bound(longint v);
    if (v < 0) return 32'd0;
    if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // Saturate a reported position to 0..2^31-1.
  function automatic logic [30:0] clamp_out(longint v);
    if (v < 0) return 31'd0;
    if (v > OUT_POS_MAX) return 31'h7FFF_FFFF;
    return v[30:0];
  endfunction

  function automatic void open_gap(int at, int n);
    for (int k = tbl_n - 1; k >= at; k--) tbl[k + n] = tbl[k];
    for (int k = 0; k < n; k++) tbl[at + k] = 32'd0;
    tbl_n += n;
  endfunction

  function automatic void close_gap(int at, int n);
    for (int k = at; k < tbl_n - n; k++) tbl[k] = tbl[k + n];
    tbl_n -= n;
  endfunction

  // Find the last boundary at or below the offset and the offset local to it.
  function automatic longint find_slot(longint off, output longint local_off);
    longint i, last, fill;
    i = 0; last = 0; fill = 0;
    while (i < tbl_n && off >= longint'(tbl[i])) begin
      last = tbl[i];
      if (i & 1) fill += last - longint'(tbl[i - 1]);
      i++;
    end
    i--;
    if (i & 1) fill = last - fill;
    local_off = fill + off - last;
    return i;
  endfunction

  // Add a covered range, merging with a neighbor that touches it.
  function automatic bit add_cover(longint off, longint cnt);
    int pos;
    longint stop;
    pos = 0;
    stop = off + cnt;
    while (pos < tbl_n && off > longint'(tbl[pos])) pos++;
    if (pos < tbl_n && longint'(tbl[pos]) == off) begin
      tbl[pos] = clamp_bound(stop);
      if (pos + 1 < tbl_n && tbl[pos] == tbl[pos + 1]) close_gap(pos, 2);
    end else if (pos < tbl_n && longint'(tbl[pos]) == stop) begin
      tbl[pos] = clamp_bound(off);
    end else begin
      if (tbl_n + 2 > TBL_DEPTH) return 1'b0;
      open_gap(pos, 2);
      tbl[pos] = clamp_bound(off);
      tbl[pos + 1] = clamp_bound(stop);
    end
    return 1'b1;
  endfunction

  function automatic bit insert_gap(longint off, longint cnt, bit mode);
    logic [31:0] saved [TBL_DEPTH];
    int saved_n;
    longint local_off, slot;
    saved = tbl;
    saved_n = tbl_n;
    slot = find_slot(off, local_off);
    for (longint p = slot + 1; p < tbl_n; p++) tbl[p] = clamp_bound(longint'(tbl[p]) + cnt);
    if (longint'(mode) == (slot & 1)) begin
      if (!add_cover(off, cnt)) begin
        tbl = saved;
        tbl_n = saved_n;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit remove_span(longint off, longint cnt);
    int pos, pos2;
    longint stop;
    stop = off + cnt;
    for (pos = 0; pos < tbl_n; pos++) begin
      if (longint'(tbl[pos]) < off) continue;
      for (pos2 = pos; pos2 < tbl_n; pos2++)
        if (longint'(tbl[pos2]) > stop) break;
      if (pos & 1) begin
        if (pos == pos2) begin
          if (tbl_n + 2 > TBL_DEPTH) return 1'b0;
          pos2 += 2;
          open_gap(pos, 2);
        end
        tbl[pos] = clamp_bound(off);
      end
      if (pos2 & 1) tbl[pos2 - 1] = clamp_bound(stop);
      if (!(pos & pos2 & 1)) begin
        pos += pos & 1;
        pos2 -= pos2 & 1;
      end
      if (pos < pos2) close_gap(pos, pos2 - pos);
      for (; pos < tbl_n; pos++) tbl[pos] = clamp_bound(longint'(tbl[pos]) - cnt);
      break;
    end
    return 1'b1;
  endfunction

  // Work out the response to one request and update the predicted list.
  function automatic isd_rsp_t predict_rsp(isd_req_t it);
    isd_rsp_t r;
    longint off, cnt, idx, rs, re, ps, pe, span, x;
    bit ok;
    r = '0;
    ok = 1'b1;
    off = it.position;
    cnt = it.length;
    case (it.req_type)
      REQ_ADD:    if (cnt > 0) ok = add_cover(off, cnt);
      REQ_INSERT: if (cnt > 0) ok = insert_gap(off, cnt, it.flag_bit);
      REQ_DELETE: if (cnt > 0) ok = remove_span(off, cnt);
      REQ_LOCATE: begin
        idx = find_slot(off, rs);
        if (idx > 127) idx = 127;
        r.found_index = idx[7:0];
        r.result_pos = clamp_out(rs);
      end
      REQ_SPAN: begin
        ps = find_slot(off, rs);
        pe = find_slot(off + cnt, re);
        if ((ps ^ longint'(it.flag_bit)) & 1) rs = off - rs;
        if ((pe ^ longint'(it.flag_bit)) & 1) re = off + cnt - re;
        span = re - rs;
        if (span > 64'sd2147483647) span = 64'sd2147483647;
        if (span < -64'sd2147483648) span = -64'sd2147483648;
        r.result_pos = clamp_out(rs);
        r.span_len = span[31:0];
      end
      REQ_EXPAND: begin
        x = off;
        for (int i = 0; i + 1 < tbl_n && longint'(tbl[i]) <= x; i += 2)
          x += longint'(tbl[i + 1]) - longint'(tbl[i]);
        r.result_pos = clamp_out(x);
      end
      default: ;
    endcase
    r.status = !ok;
    return r;
  endfunction

  // Send one item, predict its response on acceptance, then maybe idle.
  task automatic send_item(logic [2:0] kind, logic [30:0] pos, logic [30:0] len, bit flag);
    isd_req_t it;
    int gap;
    it.req_type = kind;
    it.position = pos;
    it.length = len;
    it.flag_bit = flag;
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    rsp_q.push_back(predict_rsp(it));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Response ready with random stall bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    isd_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, actual %p", $realtime, rsp);
      end else begin
        want = rsp_q.pop_front();
        if (rsp.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, rsp.status);
        end
        if (rsp.found_index !== want.found_index) begin
          errors++;
          $display("%0t: found_index expected %0d actual %0d", $realtime,
                   want.found_index, rsp.found_index);
        end
        if (rsp.result_pos !== want.result_pos) begin
          errors++;
          $display("%0t: result_pos expected %0d actual %0d", $realtime,
                   want.result_pos, rsp.result_pos);
        end
        if (rsp.span_len !== want.span_len) begin
          errors++;
          $display("%0t: span_len expected %0d actual %0d", $realtime,
                   want.span_len, rsp.span_len);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extremes, every operation, zero length, saturation and unknown codes.
  task automatic test_directed;
    send_item(REQ_LOCATE, 31'd0, 31'd0, 1'b0);
    send_item(REQ_ADD, 31'd10, 31'd5, 1'b0);
    send_item(REQ_ADD, 31'd15, 31'd5, 1'b0);
    send_item(REQ_ADD, 31'd5, 31'd5, 1'b0);
    send_item(REQ_ADD, 31'd40, 31'd0, 1'b0);
    send_item(REQ_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_item(REQ_INSERT, 31'd7, 31'h7FFF_FFFF, 1'b1);
    send_item(REQ_INSERT, 31'd2, 31'd3, 1'b0);
    send_item(REQ_INSERT, 31'd2, 31'd3, 1'b1);
    send_item(REQ_INSERT, 31'd2, 31'd0, 1'b1);
    send_item(REQ_LOCATE, 31'd9, 31'd0, 1'b0);
    send_item(REQ_LOCATE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_item(REQ_SPAN, 31'd3, 31'd20, 1'b0);
    send_item(REQ_SPAN, 31'd3, 31'd20, 1'b1);
    send_item(REQ_SPAN, 31'd0, 31'h7FFF_FFFF, 1'b1);
    send_item(REQ_SPAN, 31'd8, 31'd0, 1'b0);
    send_item(REQ_EXPAND, 31'd0, 31'd0, 1'b0);
    send_item(REQ_EXPAND, 31'h7FFF_FFFF, 31'd0, 1'b0);
    send_item(REQ_DELETE, 31'd6, 31'd2, 1'b0);
    send_item(REQ_DELETE, 31'd6, 31'd0, 1'b0);
    send_item(3'd6, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_item(3'd7, 31'd1, 31'd1, 1'b0);
    send_item(REQ_DELETE, 31'd0, 31'h7FFF_FFFF, 1'b0);
  endtask

  // Fill the store, try edits that need two more boundaries, then query and clear it.
  task automatic test_store_full;
    for (int k = 0; k < TBL_DEPTH / 2; k++) send_item(REQ_ADD, 31'(k * 10), 31'd3, 1'b0);
    send_item(REQ_ADD, 31'd1000, 31'd5, 1'b0);
    send_item(REQ_INSERT, 31'd5, 31'd2, 1'b1);
    send_item(REQ_DELETE, 31'd21, 31'd1, 1'b0);
    send_item(REQ_LOCATE, 31'd315, 31'd0, 1'b0);
    send_item(REQ_EXPAND, 31'd400, 31'd0, 1'b0);
    send_item(REQ_DELETE, 31'd0, 31'd1000, 1'b0);
  endtask

  // Mostly clustered small offsets so edits interact, with some wide values.
  task automatic test_random(int n);
    int sel;
    logic [2:0] kind;
    logic [30:0] pos, len;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) kind = REQ_ADD;
      else if (sel < 45) kind = REQ_INSERT;
      else if (sel < 60) kind = REQ_DELETE;
      else if (sel < 72) kind = REQ_LOCATE;
      else if (sel < 84) kind = REQ_SPAN;
      else if (sel < 96) kind = REQ_EXPAND;
      else kind = 3'($urandom_range(6, 7));
      sel = $urandom_range(0, 9);
      if (sel < 7) pos = 31'($urandom_range(0, 300));
      else if (sel < 9) pos = 31'($urandom_range(0, 5000));
      else pos = 31'($urandom());
      sel = $urandom_range(0, 9);
      if (sel == 0) len = '0;
      else if (sel < 8) len = 31'($urandom_range(1, 40));
      else if (sel == 8) len = 31'($urandom_range(1, 3000));
      else len = 31'($urandom());
      send_item(kind, pos, len, 1'($urandom()));
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b1;
    errors = 0;
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    for (int k = 0; k < TBL_DEPTH; k++) tbl[k] = '0;
    tbl_n = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random(1700);
    quiet = 1'b1;
    test_random(300);
    req_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
